// ===== hw/rtl/tkps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k probability selector package
// Shared widths, constants, slot and cell control types.
// ----------------------------------------------------------------------------
package tkps_pkg;

	localparam int PROB_FRAC_BITS = 16;
	localparam int PROB_W         = 17;
	localparam int IDX_W          = 18;
	localparam int CNT_W          = 3;

	localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

	// One kept entry of the ranked list
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  tok;
		logic [PROB_W-1:0] prob;
	} tkps_slot_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic load;   // try to insert the incoming probability
		logic drain;  // shift the list one rank toward the head
		logic clear;  // empty the cell
	} tkps_cell_ctl_t;

	typedef enum logic {
		ST_RUN,
		ST_DRAIN
	} tkps_state_t;

endpackage : tkps_pkg
`default_nettype wire

// ===== hw/rtl/tkps_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k selector cell
// One rank of the sorted list: compares, inserts, shifts down or drains up.
// ----------------------------------------------------------------------------
module tkps_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tkps_pkg::tkps_cell_ctl_t     ctl,
	input  wire logic [tkps_pkg::PROB_W-1:0]  new_prob,
	input  wire logic [tkps_pkg::IDX_W-1:0]   new_tok,
	input  wire tkps_pkg::tkps_slot_t         prev_slot,   // better rank
	input  wire logic                         prev_beats,
	input  wire tkps_pkg::tkps_slot_t         next_slot,   // worse rank
	output tkps_pkg::tkps_slot_t              slot,
	output logic                              beats,
	output tkps_pkg::tkps_slot_t              slot_nxt
);

	tkps_pkg::tkps_slot_t slot_q;

	// Empty slot loses to anything; a tie keeps the earlier token.
	assign beats = !slot_q.valid || (new_prob > slot_q.prob);

	always_comb begin
		slot_nxt = slot_q;
		priority if (ctl.clear) begin
			slot_nxt = '0;
		end else if (ctl.drain) begin
			slot_nxt = next_slot;
		end else if (ctl.load) begin
			if (prev_beats) begin
				slot_nxt = prev_slot;
			end else if (beats) begin
				slot_nxt.valid = 1'b1;
				slot_nxt.tok   = new_tok;
				slot_nxt.prob  = new_prob;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_nxt;
		end
	end

	assign slot = slot_q;

endmodule : tkps_cell
`default_nettype wire

// ===== hw/rtl/top_k_probability_selector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k probability selector
// Streaming insertion top-k over a token distribution with early exit.
// ----------------------------------------------------------------------------
// Takes one token probability per input beat (unsigned, 65536 = 1.0; larger
// values saturate to 1.0) and keeps the MAX_TOP best in a row of cells sorted
// best first; ties keep the earlier token. Token positions count from 0 and
// wrap after VOCAB_MAX - 1. A running sum saturating at 1.0 stops the run
// early once 1.0 minus the sum is at most the kept value at rank top_count;
// later items are counted but otherwise ignored. On the beat marked last_item
// the block emits top_count result beats (top_count above MAX_TOP acts as
// MAX_TOP), best first, empty ranks with slot_filled low and zero payload,
// last_result on the final one, then clears. Timing: one item per cycle
// while a run streams in; after the last item the input is stalled for
// top_count result beats, because results leave through the head cell while
// the row shifts toward it. top_count of 0 emits nothing and still clears.
// top_count is written through cfg_valid/cfg_ready (always ready); reset
// value is 1.
// ----------------------------------------------------------------------------
module top_k_probability_selector #(
	parameter int MAX_TOP   = 5,
	parameter int VOCAB_MAX = 262144
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tkps_pkg::CNT_W-1:0]   top_count,
	// item channel
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [tkps_pkg::PROB_W-1:0]  prob,
	input  wire logic                         last_item,
	// result channel
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output logic                              slot_filled,
	output logic [tkps_pkg::IDX_W-1:0]        token_index,
	output logic [tkps_pkg::PROB_W-1:0]       token_prob,
	output logic                              last_result
);

	localparam int POS_W = (VOCAB_MAX > 1) ? $clog2(VOCAB_MAX) : 1;

	// configuration register
	logic [tkps_pkg::CNT_W-1:0] top_count_q;
	logic [tkps_pkg::CNT_W-1:0] k_eff;

	// run state
	logic [POS_W-1:0]            pos_q;
	logic [tkps_pkg::PROB_W-1:0] sum_q;
	logic                        stopped_q;
	logic [tkps_pkg::CNT_W-1:0]  rem_q;      // result beats still to send
	tkps_pkg::tkps_state_t       state_q, state_d;

	// handshakes
	logic item_acc, res_acc;

	// datapath
	logic [tkps_pkg::PROB_W-1:0] p_sat;
	logic [tkps_pkg::PROB_W:0]   sum_wide;
	logic [tkps_pkg::PROB_W-1:0] sum_nxt;
	logic [tkps_pkg::PROB_W-1:0] remain;
	logic [tkps_pkg::IDX_W-1:0]  tok_cur;
	tkps_pkg::tkps_slot_t        sel_nxt;   // rank top_count after this beat
	logic                        stop_set;

	// cell row
	tkps_pkg::tkps_cell_ctl_t    ctl;
	tkps_pkg::tkps_slot_t        slot     [MAX_TOP];
	tkps_pkg::tkps_slot_t        slot_nxt [MAX_TOP];
	logic                        beats    [MAX_TOP];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= tkps_pkg::CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			top_count_q <= top_count;
		end
	end

	always_comb begin
		if (int'(top_count_q) > MAX_TOP) begin
			k_eff = tkps_pkg::CNT_W'(MAX_TOP);
		end else begin
			k_eff = top_count_q;
		end
	end

	assign item_acc = item_valid && !item_stall;
	assign res_acc  = res_valid && !res_stall;

	// probability saturation and running sum
	assign p_sat    = (prob > tkps_pkg::PROB_ONE) ? tkps_pkg::PROB_ONE : prob;
	assign sum_wide = {1'b0, sum_q} + {1'b0, p_sat};
	assign sum_nxt  = (sum_wide > {1'b0, tkps_pkg::PROB_ONE}) ? tkps_pkg::PROB_ONE
	                                                          : sum_wide[tkps_pkg::PROB_W-1:0];
	assign remain   = tkps_pkg::PROB_ONE - sum_nxt;
	assign tok_cur  = tkps_pkg::IDX_W'(pos_q);

	// pick the post-insert entry at rank top_count
	always_comb begin
		sel_nxt = '0;
		for (int i = 0; i < MAX_TOP; i++) begin
			if ((i + 1) == int'(k_eff)) begin
				sel_nxt = slot_nxt[i];
			end
		end
	end

	assign stop_set = ctl.load && (k_eff != '0) && sel_nxt.valid && (remain <= sel_nxt.prob);

	// ---- control FSM ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tkps_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		item_stall = 1'b0;
		res_valid  = 1'b0;
		unique case (state_q)
			tkps_pkg::ST_RUN: begin
				ctl.load = item_acc && !stopped_q;
				// zero count: nothing to send, clear on the last beat
				ctl.clear = item_acc && last_item && (k_eff == '0);
				if (item_acc && last_item && (k_eff != '0)) begin
					state_d = tkps_pkg::ST_DRAIN;
				end
			end
			tkps_pkg::ST_DRAIN: begin
				item_stall = 1'b1;
				res_valid  = 1'b1;
				ctl.drain  = res_acc;
				ctl.clear  = res_acc && (rem_q == tkps_pkg::CNT_W'(1));
				if (res_acc && (rem_q == tkps_pkg::CNT_W'(1))) begin
					state_d = tkps_pkg::ST_RUN;
				end
			end
			default: begin
				state_d = tkps_pkg::ST_RUN;
			end
		endcase
	end

	// ---- run counters ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			stopped_q <= 1'b0;
			rem_q     <= '0;
		end else begin
			if (item_acc) begin
				if (last_item) begin
					pos_q     <= '0;
					sum_q     <= '0;
					stopped_q <= 1'b0;
					rem_q     <= k_eff;
				end else begin
					pos_q <= (pos_q == POS_W'(VOCAB_MAX - 1)) ? '0 : pos_q + POS_W'(1);
					if (!stopped_q) begin
						sum_q     <= sum_nxt;
						stopped_q <= stop_set;
					end
				end
			end else if (res_acc) begin
				rem_q <= rem_q - tkps_pkg::CNT_W'(1);
			end
		end
	end

	// ---- cell row, best rank at index 0 ----
	for (genvar i = 0; i < MAX_TOP; i++) begin : g_cell
		tkps_pkg::tkps_slot_t prev_s, next_s;
		logic                 prev_b;

		if (i == 0) begin : g_head
			assign prev_s = '0;
			assign prev_b = 1'b0;
		end else begin : g_body
			assign prev_s = slot[i-1];
			assign prev_b = beats[i-1];
		end

		if (i == MAX_TOP - 1) begin : g_tail
			assign next_s = '0;
		end else begin : g_mid
			assign next_s = slot[i+1];
		end

		tkps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_prob   (p_sat),
			.new_tok    (tok_cur),
			.prev_slot  (prev_s),
			.prev_beats (prev_b),
			.next_slot  (next_s),
			.slot       (slot[i]),
			.beats      (beats[i]),
			.slot_nxt   (slot_nxt[i])
		);
	end

	// ---- result beat comes straight from the head cell ----
	assign slot_filled = slot[0].valid;
	assign token_index = slot[0].valid ? slot[0].tok  : '0;
	assign token_prob  = slot[0].valid ? slot[0].prob : '0;
	assign last_result = (rem_q == tkps_pkg::CNT_W'(1));

	// ---- assertions ----
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (rem_q != '0))
		else $error("result beat pending with no remaining count");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid && !item_stall && last_item))
		else $error("results started without a last item");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && last_result) |=> (!res_valid && (slot[0].valid == 1'b0)))
		else $error("row not cleared after final result beat");

	for (genvar i = 0; i + 1 < MAX_TOP; i++) begin : g_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			slot[i+1].valid |-> (slot[i].valid && (slot[i].prob >= slot[i+1].prob)))
			else $error("cell row out of order");
	end

endmodule : top_k_probability_selector
`default_nettype wire
